/* sv/sba_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_pkg: shared types and constants
// Class codes, status codes and fixed sizes of the slab allocator.
// ---------------------------------------------------------------------------
package sba_pkg;

  localparam int unsigned SmallBytes  = 16;
  localparam int unsigned SlabShift   = 9;
  localparam int unsigned LanesPerWord = 16;

  typedef enum logic [1:0] {
    CLS_PARTIAL    = 2'd0,
    CLS_FREE       = 2'd1,
    CLS_FULL_SMALL = 2'd2,
    CLS_FULL_LARGE = 2'd3
  } slab_cls_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOMEM        = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_BOUNDS       = 3'd3,
    ST_NOT_SMALL    = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_e;

  typedef enum logic {
    CFG_POOL_BASE  = 1'b0,
    CFG_SLAB_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic [31:0] ClassWordFree = 32'h5555_5555;
  localparam logic [31:0] AllBlocks     = 32'hFFFF_FFFF;

endpackage

/* sv/two_level_bitmap_slab_allocator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_bitmap_slab_allocator_top: slab allocator with two size classes
// Slab classes live packed sixteen to a word in one memory, block bitmaps in
// a second memory; a sequencer scans, then read-modify-writes both.
// ---------------------------------------------------------------------------
// After reset a clearing pass over all MAX_SLABS slabs initializes both
// memories; busy is high and no request is taken. A request is taken when
// start is high and busy low; its result appears for one cycle with done_o
// and cannot be held off. An oversized request answers the next cycle. An
// allocate scans the class memory a word of sixteen slabs at a time (read in
// S_SRD, evaluated in S_SEV), up to ceil(count/16) words, then reads and
// writes the chosen slab (S_ARD, S_AWR). A free checks bounds (S_FCK1,
// S_FCK2), answering there on failure, then reads and writes (S_FRD, S_FWR).
module two_level_bitmap_slab_allocator_top #(
  parameter int unsigned MAX_SLABS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        mode_i,
  input  logic [31:0] size_i,
  input  logic [31:0] address_i,
  output logic        done_o,
  output logic [31:0] block_address_o,
  output logic [9:0]  granted_size_o,
  output logic [2:0]  status_o
);
  import sba_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SLABS);
  localparam int unsigned CW = $clog2(MAX_SLABS + 1);
  localparam int unsigned NW = (MAX_SLABS + LanesPerWord - 1) / LanesPerWord;
  localparam int unsigned WW = (NW > 1) ? $clog2(NW) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SEV, S_ARD, S_AWR, S_FCK1, S_FCK2, S_FRD, S_FWR
  } state_e;

  state_e      state_q;
  logic [31:0] pool_base_q;
  logic [8:0]  slab_count_q;
  logic [CW-1:0] live;

  logic        small_q;
  logic [31:0] addr_q;
  logic [31:0] size_q;
  logic [SW-1:0] clr_q;
  logic [WW-1:0] w_q;
  logic [SW-1:0] slab_q;
  logic [SW-1:0] free_slab_q;
  logic          free_found_q;
  logic [4:0]    blk_q;
  logic [32:0]   sum_q, end_q;
  logic          lo_ok_q;
  logic [31:0]   off_q;

  // memory ports
  logic          cw_we, bm_we;
  logic [WW-1:0] cw_waddr, cw_raddr;
  logic [31:0]   cw_wdata, cw_rdata;
  logic [SW-1:0] bm_waddr, bm_raddr;
  logic [31:0]   bm_wdata, bm_rdata;

  assign live = (32'(slab_count_q) > 32'(MAX_SLABS)) ? CW'(MAX_SLABS) : CW'(slab_count_q);

  sba_ram #(.Width(32), .Depth(NW), .AddrW(WW)) u_cls_ram (
    .clk_i, .we_i(cw_we), .waddr_i(cw_waddr), .wdata_i(cw_wdata),
    .raddr_i(cw_raddr), .rdata_o(cw_rdata)
  );

  sba_ram #(.Width(32), .Depth(MAX_SLABS), .AddrW(SW)) u_bm_ram (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

  // scan of one class word
  logic [LanesPerWord-1:0] hit_p, hit_f;
  logic [3:0] first_p, first_f;
  logic       any_p, any_f;
  logic       last_word;
  always_comb begin
    for (int j = 0; j < LanesPerWord; j++) begin
      hit_p[j] = (cw_rdata[2*j +: 2] == CLS_PARTIAL) &&
                 (16'({w_q, 4'(j)}) < 16'(live));
      hit_f[j] = (cw_rdata[2*j +: 2] == CLS_FREE) &&
                 (16'({w_q, 4'(j)}) < 16'(live));
    end
    first_p = '0;
    first_f = '0;
    for (int j = LanesPerWord - 1; j >= 0; j--) begin
      if (hit_p[j]) first_p = 4'(j);
      if (hit_f[j]) first_f = 4'(j);
    end
    any_p = |hit_p;
    any_f = |hit_f;
    last_word = (16'({w_q, 4'b0}) + 16'(LanesPerWord)) >= 16'(live);
  end

  // chosen slab word / bitmap edit
  logic [3:0]  lane;
  logic [1:0]  cur_cls;
  logic [4:0]  low_blk;
  logic        bm_full;
  logic [31:0] bm_set, bm_clr;
  logic        blk_set;
  always_comb begin
    lane    = slab_q[3:0];
    cur_cls = cw_rdata[{lane, 1'b0} +: 2];
    low_blk = '0;
    for (int k = 31; k >= 0; k--) begin
      if (!bm_rdata[k]) low_blk = 5'(k);
    end
    bm_full = (bm_rdata == AllBlocks);
    bm_set  = bm_rdata | (32'd1 << low_blk);
    bm_clr  = bm_rdata & ~(32'd1 << blk_q);
    blk_set = bm_rdata[blk_q];
  end

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [3:0] l, logic [1:0] c);
    logic [31:0] r;
    r = w;
    for (int j = 0; j < LanesPerWord; j++) begin
      if (4'(j) == l) r[2*j +: 2] = c;
    end
    return r;
  endfunction

  // memory control
  always_comb begin
    cw_we    = 1'b0;
    bm_we    = 1'b0;
    cw_waddr = WW'(slab_q >> 4);
    bm_waddr = slab_q;
    cw_wdata = cw_rdata;
    bm_wdata = bm_rdata;
    cw_raddr = WW'(slab_q >> 4);
    bm_raddr = slab_q;
    unique case (state_q)
      S_CLR: begin
        cw_we    = 1'b1;
        bm_we    = 1'b1;
        cw_waddr = WW'(clr_q >> 4);
        bm_waddr = clr_q;
        cw_wdata = ClassWordFree;
        bm_wdata = '0;
      end
      S_SRD: cw_raddr = w_q;
      S_AWR: begin
        if (small_q) begin
          if (!bm_full) begin
            cw_we    = 1'b1;
            bm_we    = 1'b1;
            bm_wdata = bm_set;
            cw_wdata = put_lane(cw_rdata, lane,
                                (bm_set == AllBlocks) ? CLS_FULL_SMALL : CLS_PARTIAL);
          end
        end else begin
          cw_we    = 1'b1;
          cw_wdata = put_lane(cw_rdata, lane, CLS_FULL_LARGE);
        end
      end
      S_FWR: begin
        if (small_q) begin
          if ((cur_cls == CLS_PARTIAL || cur_cls == CLS_FULL_SMALL) && blk_set) begin
            cw_we    = 1'b1;
            bm_we    = 1'b1;
            bm_wdata = bm_clr;
            cw_wdata = put_lane(cw_rdata, lane,
                                (bm_clr == '0) ? CLS_FREE : CLS_PARTIAL);
          end
        end else if (cur_cls == CLS_FULL_LARGE) begin
          cw_we    = 1'b1;
          cw_wdata = put_lane(cw_rdata, lane, CLS_FREE);
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLR;
      pool_base_q     <= '0;
      slab_count_q    <= 9'd256;
      clr_q           <= '0;
      done_o          <= 1'b0;
      block_address_o <= '0;
      granted_size_o  <= '0;
      status_o        <= ST_OK;
      w_q             <= '0;
      free_found_q    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
          CFG_SLAB_COUNT: slab_count_q <= cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == MAX_SLABS - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            small_q <= (size_i <= SmallBytes);
            size_q  <= size_i;
            addr_q  <= address_i;
            if (size_i > 32'd512) begin
              done_o          <= 1'b1;
              block_address_o <= '0;
              granted_size_o  <= '0;
              status_o        <= ST_TOO_LARGE;
            end else if (!mode_i) begin
              w_q          <= '0;
              free_found_q <= 1'b0;
              state_q      <= S_SRD;
            end else begin
              state_q <= S_FCK1;
            end
          end
        end
        S_SRD: state_q <= S_SEV;
        S_SEV: begin
          if (small_q && any_p) begin
            slab_q  <= SW'({w_q, first_p});
            state_q <= S_ARD;
          end else if (!small_q && any_f) begin
            slab_q  <= SW'({w_q, first_f});
            state_q <= S_ARD;
          end else begin
            if (any_f && !free_found_q) begin
              free_found_q <= 1'b1;
              free_slab_q  <= SW'({w_q, first_f});
            end
            if (last_word) begin
              if (small_q && (free_found_q || any_f)) begin
                slab_q  <= free_found_q ? free_slab_q : SW'({w_q, first_f});
                state_q <= S_ARD;
              end else begin
                done_o          <= 1'b1;
                block_address_o <= '0;
                granted_size_o  <= '0;
                status_o        <= ST_NOMEM;
                state_q         <= S_IDLE;
              end
            end else begin
              w_q     <= w_q + 1'b1;
              state_q <= S_SRD;
            end
          end
        end
        S_ARD: state_q <= S_AWR;
        S_AWR: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
          if (small_q && bm_full) begin
            block_address_o <= '0;
            granted_size_o  <= '0;
            status_o        <= ST_NOMEM;
          end else if (small_q) begin
            block_address_o <= pool_base_q + 32'({slab_q, low_blk, 4'b0});
            granted_size_o  <= 10'd16;
            status_o        <= ST_OK;
          end else begin
            block_address_o <= pool_base_q + 32'({slab_q, 9'b0});
            granted_size_o  <= 10'd512;
            status_o        <= ST_OK;
          end
        end
        S_FCK1: begin
          sum_q   <= {1'b0, addr_q} + {1'b0, size_q};
          end_q   <= {1'b0, pool_base_q} + 33'({live, 9'b0});
          lo_ok_q <= (addr_q >= pool_base_q);
          off_q   <= addr_q - pool_base_q;
          state_q <= S_FCK2;
        end
        S_FCK2: begin
          if (!lo_ok_q || (sum_q > end_q) ||
              ({9'b0, off_q[31:SlabShift]} >= 32'(live))) begin
            done_o          <= 1'b1;
            block_address_o <= '0;
            granted_size_o  <= '0;
            status_o        <= ST_BOUNDS;
            state_q         <= S_IDLE;
          end else begin
            slab_q  <= off_q[SlabShift +: SW];
            blk_q   <= off_q[8:4];
            state_q <= S_FRD;
          end
        end
        S_FRD: state_q <= S_FWR;
        S_FWR: begin
          done_o          <= 1'b1;
          block_address_o <= '0;
          granted_size_o  <= '0;
          state_q         <= S_IDLE;
          if (small_q) begin
            if (!(cur_cls == CLS_PARTIAL || cur_cls == CLS_FULL_SMALL)) begin
              status_o <= ST_NOT_SMALL;
            end else if (!blk_set) begin
              status_o <= ST_ALREADY_FREE;
            end else begin
              status_o <= ST_OK;
            end
          end else begin
            status_o <= (cur_cls == CLS_FULL_LARGE) ? ST_OK : ST_ALREADY_FREE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while sequencer active");
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_size_o != '0) |-> status_o == ST_OK)
    else $error("grant without ok status");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (block_address_o == '0 && granted_size_o == '0))
    else $error("failed request carries an address");
  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !done_o) else $error("result during clearing pass");

endmodule

/* sv/sba_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_ram: simple dual-port memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
